>>> hdl/imt_pkg.sv
// Package for the IRC message tokenizer: field widths, character codes,
// parser phases, token kinds and the result record. No dependencies.
`timescale 1ns / 1ps
package imt_pkg;

	localparam int MAX_MESSAGE_BYTES = 512;
	localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int START_W           = 9;
	localparam int LEN_W             = 10;
	localparam int ARGNO_W           = 8;
	localparam int DATA_W            = 8;
	localparam int OUT_DATA_W        = 32;

	localparam logic [POS_W-1:0]   MAX_POS    = POS_W'(MAX_MESSAGE_BYTES);
	localparam logic [ARGNO_W-1:0] ARGNO_MAX  = '1;
	localparam logic [DATA_W-1:0]  COLON_CHAR = 8'h3A;
	localparam logic [DATA_W-1:0]  SPACE_CHAR = 8'h20;

	typedef enum logic [2:0] {
		PH_START        = 3'd0,
		PH_PREFIX       = 3'd1,
		PH_AFTER_PREFIX = 3'd2,
		PH_COMMAND      = 3'd3,
		PH_GAP          = 3'd4,
		PH_ARG          = 3'd5,
		PH_TRAILING     = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PREFIX   = 3'd0,
		KIND_COMMAND  = 3'd1,
		KIND_ARG      = 3'd2,
		KIND_TRAILING = 3'd3,
		KIND_END      = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [START_W-1:0]   start;
		logic [LEN_W-1:0]     length;
		logic [ARGNO_W-1:0]   argno;
		logic                 ovf;
		logic                 done;
	} res_t;

endpackage

>>> hdl/irc_message_tokenizer.sv
// IRC message tokenizer top level: input register, per-byte parser and
// a four-entry result queue. Depends on imt_pkg.
//
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tdata[7:0] data_byte, tlast final_byte
// m_*      out  tvalid/tready      tdata spans, tuser token_kind, tlast message_done
//
// One byte per cycle unless stalled; a result passes the input register and the queue.
// A byte that yields two results writes both to the queue; they leave one at a time.
// The input register stalls while the result queue holds more than two items.
// arst_n clears the parser state and empties the queue.
`timescale 1ns / 1ps
module irc_message_tokenizer
	import imt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_W-1:0]     s_tdata,   // [7:0] data_byte
	input  logic                  s_tlast,   // final_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [8:0] span_start, [18:9] span_length,
	                                         // [26:19] argument_number,
	                                         // [27] length_overflow, [31:28] zero
	output logic [2:0]            m_tuser,   // [2:0] token_kind
	output logic                  m_tlast    // message_done
);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              final_s1;

	phase_t             phase_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   open_q;
	logic [ARGNO_W-1:0] argc_q;
	logic               ovf_q;

	res_t              queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic proc;
	logic pop;

	phase_t             phase_d;
	logic [POS_W-1:0]   pos_d;
	logic [POS_W-1:0]   open_d;
	logic [ARGNO_W-1:0] argc_d;
	logic               ovf_d;
	res_t               r0;
	res_t               r1;
	logic [1:0]         n_res;

	function automatic logic [POS_W-1:0] span(logic [POS_W-1:0] e, logic [POS_W-1:0] o);
		return (e > o) ? POS_W'(e - o) : '0;
	endfunction

	function automatic res_t mk(kind_t k, logic [POS_W-1:0] s, logic [POS_W-1:0] l,
			logic [ARGNO_W-1:0] a, logic ov, logic d);
		res_t             r;
		logic [POS_W-1:0] sc;
		logic [POS_W-1:0] lc;
		sc       = (s > POS_W'(MAX_POS - 1'b1)) ? POS_W'(MAX_POS - 1'b1) : s;
		lc       = (l > MAX_POS) ? MAX_POS : l;
		r.kind   = k;
		r.start  = START_W'(sc);
		r.length = LEN_W'(lc);
		r.argno  = a;
		r.ovf    = ov;
		r.done   = d;
		return r;
	endfunction

	assign proc     = valid_s1 && (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign s_tready = !valid_s1 || proc;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	always_comb begin
		logic [POS_W-1:0]   off;
		logic [POS_W:0]     sum;
		logic [POS_W-1:0]   endp;
		logic               ovf_now;
		logic [ARGNO_W-1:0] argc_inc;
		logic               is_colon;
		logic               is_space;
		logic [ARGNO_W-1:0] fin_arg;
		kind_t              fin_kind;
		res_t               fin_cmd;
		off      = (pos_q > MAX_POS) ? MAX_POS : pos_q;
		sum      = {1'b0, off} + (POS_W+1)'(1);
		endp     = (sum > {1'b0, MAX_POS}) ? MAX_POS : sum[POS_W-1:0];
		ovf_now  = ovf_q || (pos_q >= MAX_POS);
		is_colon = (byte_s1 == COLON_CHAR);
		is_space = (byte_s1 == SPACE_CHAR);
		phase_d  = phase_q;
		open_d   = open_q;
		argc_d   = argc_q;
		n_res    = 2'd0;
		r0       = mk(KIND_END, '0, '0, '0, ovf_now, 1'b0);
		r1       = r0;
		unique case (phase_q)
			PH_START: begin
				if (is_colon) begin
					open_d  = endp;
					phase_d = PH_PREFIX;
				end else if (is_space) begin
					r0      = mk(KIND_COMMAND, off, '0, '0, ovf_now, 1'b0);
					n_res   = 2'd1;
					phase_d = PH_GAP;
				end else begin
					open_d  = off;
					phase_d = PH_COMMAND;
				end
			end
			PH_PREFIX: begin
				if (is_space) begin
					r0      = mk(KIND_PREFIX, open_q, span(off, open_q), '0, ovf_now, 1'b0);
					n_res   = 2'd1;
					phase_d = PH_AFTER_PREFIX;
				end
			end
			PH_AFTER_PREFIX: begin
				if (!is_space) begin
					open_d  = off;
					phase_d = PH_COMMAND;
				end
			end
			PH_COMMAND: begin
				if (is_space) begin
					r0      = mk(KIND_COMMAND, open_q, span(off, open_q), '0, ovf_now, 1'b0);
					n_res   = 2'd1;
					phase_d = PH_GAP;
				end
			end
			PH_GAP: begin
				if (is_colon) begin
					open_d  = endp;
					phase_d = PH_TRAILING;
				end else if (!is_space) begin
					open_d  = off;
					phase_d = PH_ARG;
				end
			end
			PH_ARG: begin
				if (is_space) begin
					r0      = mk(KIND_ARG, open_q, span(off, open_q), argc_q, ovf_now, 1'b0);
					n_res   = 2'd1;
					argc_d  = (argc_q != ARGNO_MAX) ? ARGNO_W'(argc_q + 1'b1) : argc_q;
					phase_d = PH_GAP;
				end
			end
			PH_TRAILING: begin
			end
			default: begin
			end
		endcase

		argc_inc = (argc_d != ARGNO_MAX) ? ARGNO_W'(argc_d + 1'b1) : argc_d;
		fin_cmd  = mk(KIND_COMMAND, endp, '0, '0, ovf_now, 1'b1);
		fin_kind = (phase_d == PH_COMMAND) ? KIND_COMMAND :
			(phase_d == PH_TRAILING) ? KIND_TRAILING : KIND_ARG;
		fin_arg  = (phase_d == PH_COMMAND) ? '0 : argc_d;

		if (final_s1) begin
			unique case (phase_d) inside
				PH_PREFIX: begin
					r0    = mk(KIND_PREFIX, open_d, span(endp, open_d), '0, ovf_now, 1'b0);
					r1    = fin_cmd;
					n_res = 2'd2;
				end
				PH_AFTER_PREFIX: begin
					if (n_res != 2'd0) begin
						r1    = fin_cmd;
						n_res = 2'd2;
					end else begin
						r0    = fin_cmd;
						n_res = 2'd1;
					end
				end
				PH_COMMAND, PH_ARG, PH_TRAILING: begin
					r0    = mk(fin_kind, open_d, span(endp, open_d), fin_arg, ovf_now, 1'b1);
					n_res = 2'd1;
					if (phase_d != PH_COMMAND) begin
						argc_d = argc_inc;
					end
				end
				default: begin
					if (n_res != 2'd0) begin
						r0.done = 1'b1;
					end else begin
						r0    = mk(KIND_END, '0, '0, '0, ovf_now, 1'b1);
						n_res = 2'd1;
					end
				end
			endcase
			phase_d = PH_START;
			pos_d   = '0;
			open_d  = '0;
			argc_d  = '0;
			ovf_d   = 1'b0;
		end else begin
			pos_d = (pos_q < MAX_POS) ? POS_W'(pos_q + 1'b1) : pos_q;
			ovf_d = ovf_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			pos_q   <= '0;
			open_q  <= '0;
			argc_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (proc) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			open_q  <= open_d;
			argc_q  <= argc_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && (n_res != 2'd0)) begin
			queue_q[wr_ptr_q] <= r0;
		end
		if (proc && (n_res == 2'd2)) begin
			queue_q[QPTR_W'(wr_ptr_q + 1'b1)] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (proc) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + QPTR_W'(n_res));
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			cnt_q <= QCNT_W'(cnt_q + (proc ? QCNT_W'(n_res) : '0) - (pop ? QCNT_W'(1) : '0));
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {{(OUT_DATA_W - START_W - LEN_W - ARGNO_W - 1){1'b0}},
		queue_q[rd_ptr_q].ovf, queue_q[rd_ptr_q].argno,
		queue_q[rd_ptr_q].length, queue_q[rd_ptr_q].start};
	assign m_tuser  = queue_q[rd_ptr_q].kind;
	assign m_tlast  = queue_q[rd_ptr_q].done;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue over depth");

	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && final_s1) |=> (phase_q == PH_START && pos_q == '0 && argc_q == '0))
		else $error("parser state not cleared after final byte");

	a_end_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_END) |-> (m_tlast && m_tdata[26:0] == '0))
		else $error("end-only result with nonzero fields");
`endif

endmodule

>>> tb/sv/tb_irc_message_tokenizer.sv
// Self-checking testbench for irc_message_tokenizer: streams IRC message bytes,
// predicts each token span in a local tokenizer and checks every result item.
// Depends on imt_pkg and the irc_message_tokenizer RTL.
`timescale 1ns / 1ps
module tb_irc_message_tokenizer;
	import imt_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 120;
	localparam int DRAIN_CYCLES = 12;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  m_tlast;

	irc_message_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// tokenizer state mirrored for prediction
	phase_t             tok_phase = PH_START;
	logic [POS_W-1:0]   byte_pos = '0;
	logic [POS_W-1:0]   tok_start = '0;
	logic [ARGNO_W-1:0] arg_count = '0;
	logic               ovf_seen = 1'b0;

	res_t        span_q[$];
	logic [7:0]  msg_buf[$];
	int unsigned burst_left = 0;
	int unsigned hold_len = 0;
	int unsigned cycles = 0;
	int unsigned errors = 0;
	int unsigned n_items = 0;
	int unsigned n_msgs = 0;
	int unsigned n_ovf_msgs = 0;
	int unsigned n_results = 0;
	res_t        want;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W:0] v);
		return (v > MAX_POS) ? MAX_POS : v[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] span_to(input logic [POS_W-1:0] stop);
		return (stop > tok_start) ? stop - tok_start : '0;
	endfunction

	function automatic logic [ARGNO_W-1:0] next_arg_index();
		logic [ARGNO_W-1:0] idx;
		idx = arg_count;
		if (arg_count != ARGNO_MAX)
			arg_count++;
		return idx;
	endfunction

	function automatic res_t make_span(input kind_t k, input logic [POS_W-1:0] st,
			input logic [POS_W-1:0] len, input logic [ARGNO_W-1:0] an, input logic dn);
		res_t r;
		r.kind   = k;
		r.start  = (st > MAX_POS - 1) ? START_W'(MAX_POS - 1) : START_W'(st);
		r.length = (len > MAX_POS) ? LEN_W'(MAX_POS) : LEN_W'(len);
		r.argno  = an;
		r.ovf    = ovf_seen;
		r.done   = dn;
		return r;
	endfunction

	function automatic void tokenize_byte(input logic [7:0] b, input logic last);
		res_t               outs[2];
		int                 n;
		logic [POS_W-1:0]   off;
		logic [POS_W-1:0]   nxt;
		kind_t              k;
		logic [ARGNO_W-1:0] an;
		n = 0;
		off = clamp_pos({1'b0, byte_pos});
		if (byte_pos >= MAX_POS)
			ovf_seen = 1'b1;
		nxt = clamp_pos({1'b0, off} + 1'b1);
		case (tok_phase)
			PH_START: begin
				if (b == COLON_CHAR) begin
					tok_start = nxt;
					tok_phase = PH_PREFIX;
				end else if (b == SPACE_CHAR) begin
					outs[n++] = make_span(KIND_COMMAND, off, '0, '0, 1'b0);
					tok_phase = PH_GAP;
				end else begin
					tok_start = off;
					tok_phase = PH_COMMAND;
				end
			end
			PH_PREFIX: begin
				if (b == SPACE_CHAR) begin
					outs[n++] = make_span(KIND_PREFIX, tok_start, span_to(off), '0, 1'b0);
					tok_phase = PH_AFTER_PREFIX;
				end
			end
			PH_AFTER_PREFIX: begin
				if (b != SPACE_CHAR) begin
					tok_start = off;
					tok_phase = PH_COMMAND;
				end
			end
			PH_COMMAND: begin
				if (b == SPACE_CHAR) begin
					outs[n++] = make_span(KIND_COMMAND, tok_start, span_to(off), '0, 1'b0);
					tok_phase = PH_GAP;
				end
			end
			PH_GAP: begin
				if (b == COLON_CHAR) begin
					tok_start = nxt;
					tok_phase = PH_TRAILING;
				end else if (b != SPACE_CHAR) begin
					tok_start = off;
					tok_phase = PH_ARG;
				end
			end
			PH_ARG: begin
				if (b == SPACE_CHAR) begin
					an = next_arg_index();
					outs[n++] = make_span(KIND_ARG, tok_start, span_to(off), an, 1'b0);
					tok_phase = PH_GAP;
				end
			end
			default: ;
		endcase

		if (!last) begin
			if (byte_pos < MAX_POS)
				byte_pos++;
		end else begin
			if (tok_phase == PH_PREFIX) begin
				outs[n++] = make_span(KIND_PREFIX, tok_start, span_to(nxt), '0, 1'b0);
				outs[n++] = make_span(KIND_COMMAND, nxt, '0, '0, 1'b1);
			end else if (tok_phase == PH_AFTER_PREFIX) begin
				outs[n++] = make_span(KIND_COMMAND, nxt, '0, '0, 1'b1);
			end else if (tok_phase == PH_COMMAND || tok_phase == PH_ARG ||
					tok_phase == PH_TRAILING) begin
				k = (tok_phase == PH_COMMAND) ? KIND_COMMAND :
					(tok_phase == PH_TRAILING) ? KIND_TRAILING : KIND_ARG;
				an = (k == KIND_COMMAND) ? '0 : next_arg_index();
				outs[n++] = make_span(k, tok_start, span_to(nxt), an, 1'b1);
			end else if (n > 0) begin
				outs[n-1].done = 1'b1;
			end else begin
				outs[n++] = make_span(KIND_END, '0, '0, '0, 1'b1);
			end
			if (ovf_seen)
				n_ovf_msgs++;
			tok_phase = PH_START;
			byte_pos  = '0;
			tok_start = '0;
			arg_count = '0;
			ovf_seen  = 1'b0;
		end
		for (int i = 0; i < n; i++)
			span_q.insert(span_q.size(), outs[i]);
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (span_q.size() == 0) begin
				$error("unexpected result: kind %0d start %0d", m_tuser, m_tdata[8:0]);
				errors++;
			end else begin
				want = span_q.pop_front();
				n_results++;
				if (m_tuser !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, m_tuser);
					errors++;
				end
				if (m_tdata[8:0] !== want.start) begin
					$error("span_start: expected %0d, got %0d", want.start, m_tdata[8:0]);
					errors++;
				end
				if (m_tdata[18:9] !== want.length) begin
					$error("span_length: expected %0d, got %0d", want.length, m_tdata[18:9]);
					errors++;
				end
				if (m_tdata[26:19] !== want.argno) begin
					$error("argument_number: expected %0d, got %0d", want.argno,
						m_tdata[26:19]);
					errors++;
				end
				if (m_tdata[27] !== want.ovf) begin
					$error("length_overflow: expected %0d, got %0d", want.ovf, m_tdata[27]);
					errors++;
				end
				if (m_tdata[31:28] !== 4'd0) begin
					$error("tdata padding: expected 0, got %0d", m_tdata[31:28]);
					errors++;
				end
				if (m_tlast !== want.done) begin
					$error("message_done: expected %0d, got %0d", want.done, m_tlast);
					errors++;
				end
			end
		end
	end

	// receiver: changing stall patterns, plus a long hold-off on request
	initial begin : receiver
		int unsigned stall_left;
		int unsigned mode;
		int unsigned mode_left;
		int unsigned tick;
		stall_left = 0;
		mode = 0;
		mode_left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_len != 0) begin
				stall_left = hold_len;
				hold_len = 0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (tick % 4) != 3;
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("irc_message_tokenizer regression: fail");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		tokenize_byte(b, last);
		n_items++;
		if (last)
			n_msgs++;
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_buf.size(); i++)
			send_byte(msg_buf[i], i == msg_buf.size() - 1);
	endtask

	function automatic void append_byte(input logic [7:0] b);
		msg_buf.insert(msg_buf.size(), b);
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			append_byte(s[i]);
	endtask

	task automatic add_spaces(input int unsigned n);
		repeat (n) append_byte(SPACE_CHAR);
	endtask

	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		if ($urandom_range(0, 3) != 0)
			return 8'h61 + 8'($urandom_range(0, 25));
		c = 8'($urandom_range(0, 255));
		while (c == SPACE_CHAR || c == COLON_CHAR)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic add_word(input int unsigned n);
		if (n != 0) begin
			append_byte(pick_char());
			repeat (n - 1)
				append_byte(($urandom_range(0, 9) == 0) ? COLON_CHAR : pick_char());
		end
	endtask

	task automatic build_random_message();
		int unsigned style;
		int unsigned k;
		msg_buf.delete();
		style = $urandom_range(0, 15);
		if (style == 0) begin
			repeat ($urandom_range(1, 24))
				append_byte(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				append_byte(COLON_CHAR);
				add_word($urandom_range(0, 8));
				add_spaces($urandom_range(1, 3));
			end else if ($urandom_range(0, 7) == 0) begin
				add_spaces($urandom_range(1, 2));
			end
			add_word($urandom_range(0, 7));
			repeat ($urandom_range(0, 6)) begin
				add_spaces($urandom_range(1, 3));
				add_word($urandom_range(1, 6));
			end
			if ($urandom_range(0, 1) == 1) begin
				add_spaces($urandom_range(1, 2));
				append_byte(COLON_CHAR);
				k = (style == 1) ? $urandom_range(40, 80) : $urandom_range(0, 12);
				repeat (k)
					append_byte(($urandom_range(0, 4) == 0) ? SPACE_CHAR : pick_char());
			end
			if ($urandom_range(0, 4) == 0)
				add_spaces($urandom_range(1, 2));
			if (style == 2 && msg_buf.size() > 1)
				repeat ($urandom_range(1, msg_buf.size() - 1))
					void'(msg_buf.pop_back());
			if (msg_buf.size() == 0)
				append_byte(pick_char());
		end
	endtask

	task automatic test_directed();
		msg_buf.delete(); add_text(" ");    send_message();
		msg_buf.delete(); add_text(":");    send_message();
		msg_buf.delete(); add_text(":p  "); send_message();
		msg_buf.delete(); add_text("A ");   send_message();
		msg_buf.delete(); append_byte(8'hFF); add_text("  "); send_message();
		msg_buf.delete(); append_byte(8'h00); add_text(" x :"); send_message();
		msg_buf.delete(); add_text(":n C a :t"); send_message();
	endtask

	task automatic test_oversize();
		msg_buf.delete();
		append_byte(COLON_CHAR);
		repeat (520) append_byte(8'h70);
		send_message();
	endtask

	task automatic test_many_args();
		msg_buf.delete();
		add_text("M");
		repeat (262) add_text(" a");
		add_text(" :t");
		send_message();
	endtask

	task automatic test_backpressure();
		msg_buf.delete();
		add_text("P");
		repeat (30) add_text(" b");
		hold_len = 400;
		send_message();
	endtask

	task automatic test_random();
		int unsigned sent;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			build_random_message();
			sent += msg_buf.size();
			send_message();
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_oversize();
		test_many_args();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (span_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d messages, %0d bytes, %0d token results checked",
			n_msgs, n_items, n_results);
		$display("%0d messages ran past the %0d-byte buffer", n_ovf_msgs, MAX_MESSAGE_BYTES);
		if (errors == 0)
			$display("irc_message_tokenizer regression: pass");
		else
			$display("irc_message_tokenizer regression: fail");
		$finish;
	end

endmodule
